// ===== design/dqne_pkg.sv =====
// Shared types and constants for the DNS query name extractor.
package dqne_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 65536;

	localparam int ETH_HDR_LEN    = 14;
	localparam int IHL_OFFSET     = 14;
	localparam int SRC_ADDR_FIRST = 26;
	localparam int SRC_ADDR_LAST  = 29;
	localparam int DST_ADDR_FIRST = 30;
	localparam int DST_ADDR_LAST  = 33;
	localparam int UDP_HDR_LEN    = 8;
	localparam int DNS_FLAGS_OFS  = 2;
	localparam int DNS_COUNT_FIRST = 6;
	localparam int DNS_COUNT_LAST  = 11;

	localparam logic [7:0] DOT_CHAR        = 8'h2E;
	localparam logic [7:0] CTRL_CHAR_LIMIT = 8'h10;

	typedef enum logic [1:0] {
		PH_HEADERS = 2'd0,
		PH_SKIP    = 2'd1,
		PH_NAME    = 2'd2,
		PH_DRAIN   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_CHAR   = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [31:0] dst_addr;
		logic [15:0] dst_port;
		logic [7:0]  name_char;
		logic        last;
	} rec_t;

endpackage

// ===== design/dqne_parse.sv =====
// Per-byte frame parser: header capture, query filter and name byte records.
module dqne_parse import dqne_pkg::*; #(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_take,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	output logic       rec_valid,
	output rec_t       rec
);

	localparam int OFF_W = $clog2(MAX_FRAME_BYTES);
	localparam int CMP_W = (OFF_W > 7) ? OFF_W : 7;

	logic [OFF_W-1:0] off_q;
	logic [3:0]       ihw_q, ihw_d;
	logic [31:0]      src_addr_q, src_addr_d;
	logic [31:0]      dst_addr_q, dst_addr_d;
	logic [15:0]      src_port_q, src_port_d;
	logic [15:0]      dst_port_q, dst_port_d;
	logic             query_q, query_d;
	logic             cz_q, cz_d;
	phase_t           phase_q, phase_d;

	logic [CMP_W-1:0] off_c, u_c, d_c;
	logic             end_c, hdr_c, past_ip_c, hdr_done_c, pass_c;

	assign off_c      = CMP_W'(off_q);
	assign u_c        = CMP_W'(ETH_HDR_LEN) + CMP_W'({ihw_q, 2'b00});
	assign d_c        = u_c + CMP_W'(UDP_HDR_LEN);
	assign end_c      = in_end || (off_q >= OFF_W'(MAX_FRAME_BYTES - 1));
	assign hdr_c      = (phase_q == PH_HEADERS);
	assign past_ip_c  = (off_c > CMP_W'(IHL_OFFSET));
	assign hdr_done_c = hdr_c && past_ip_c && (off_c == d_c + CMP_W'(DNS_COUNT_LAST));
	assign pass_c     = query_d && cz_d;

	always_comb begin
		ihw_d      = ihw_q;
		src_addr_d = src_addr_q;
		dst_addr_d = dst_addr_q;
		src_port_d = src_port_q;
		dst_port_d = dst_port_q;
		query_d    = query_q;
		cz_d       = cz_q;
		if (hdr_c) begin
			if (off_c == CMP_W'(IHL_OFFSET)) begin
				ihw_d = in_byte[3:0];
			end
			if (off_c >= CMP_W'(SRC_ADDR_FIRST) && off_c <= CMP_W'(SRC_ADDR_LAST)) begin
				src_addr_d = {src_addr_q[23:0], in_byte};
			end
			if (off_c >= CMP_W'(DST_ADDR_FIRST) && off_c <= CMP_W'(DST_ADDR_LAST)) begin
				dst_addr_d = {dst_addr_q[23:0], in_byte};
			end
			if (past_ip_c) begin
				if (off_c == u_c || off_c == u_c + CMP_W'(1)) begin
					src_port_d = {src_port_q[7:0], in_byte};
				end
				if (off_c == u_c + CMP_W'(2) || off_c == u_c + CMP_W'(3)) begin
					dst_port_d = {dst_port_q[7:0], in_byte};
				end
				if (off_c == d_c + CMP_W'(DNS_FLAGS_OFS)) begin
					query_d = ~in_byte[7];
				end
				if (off_c >= d_c + CMP_W'(DNS_COUNT_FIRST) &&
				    off_c <= d_c + CMP_W'(DNS_COUNT_LAST) && in_byte != 8'd0) begin
					cz_d = 1'b0;
				end
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HEADERS: begin
				if (hdr_done_c) begin
					phase_d = pass_c ? PH_SKIP : PH_DRAIN;
				end
			end
			PH_SKIP: begin
				phase_d = PH_NAME;
			end
			PH_NAME: begin
				if (in_byte == 8'd0) begin
					phase_d = PH_DRAIN;
				end
			end
			PH_DRAIN: begin
				phase_d = PH_DRAIN;
			end
			default: begin
				phase_d = PH_HEADERS;
			end
		endcase
	end

	always_comb begin
		rec_valid     = 1'b0;
		rec.kind      = KIND_HEADER;
		rec.src_addr  = src_addr_d;
		rec.src_port  = src_port_d;
		rec.dst_addr  = dst_addr_d;
		rec.dst_port  = dst_port_d;
		rec.name_char = 8'd0;
		rec.last      = end_c;
		unique case (phase_q)
			PH_HEADERS: begin
				rec_valid = hdr_done_c && pass_c;
			end
			PH_SKIP: begin
				rec_valid = end_c;
				rec.kind  = KIND_END;
				rec.last  = 1'b1;
			end
			PH_NAME: begin
				rec_valid = 1'b1;
				if (in_byte == 8'd0) begin
					rec.kind = KIND_END;
					rec.last = 1'b1;
				end else begin
					rec.kind      = KIND_CHAR;
					rec.name_char = (in_byte < CTRL_CHAR_LIMIT) ? DOT_CHAR : in_byte;
				end
			end
			default: begin
				rec_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q      <= '0;
			ihw_q      <= '0;
			src_addr_q <= '0;
			dst_addr_q <= '0;
			src_port_q <= '0;
			dst_port_q <= '0;
			query_q    <= 1'b0;
			cz_q       <= 1'b1;
			phase_q    <= PH_HEADERS;
		end else if (in_take) begin
			if (end_c) begin
				off_q      <= '0;
				ihw_q      <= '0;
				src_addr_q <= '0;
				dst_addr_q <= '0;
				src_port_q <= '0;
				dst_port_q <= '0;
				query_q    <= 1'b0;
				cz_q       <= 1'b1;
				phase_q    <= PH_HEADERS;
			end else begin
				off_q      <= off_q + OFF_W'(1);
				ihw_q      <= ihw_d;
				src_addr_q <= src_addr_d;
				dst_addr_q <= dst_addr_d;
				src_port_q <= src_port_d;
				dst_port_q <= dst_port_d;
				query_q    <= query_d;
				cz_q       <= cz_d;
				phase_q    <= phase_d;
			end
		end
	end

endmodule

// ===== design/dns_query_name_extractor_top.sv =====
// Top level of the DNS query name extractor: parser and result register.
//
// Takes one Ethernet frame byte per cycle on the slave side unless the output
// is stalled, starting at the destination MAC, and gives at most one record
// per byte on the master side: a header record with the IPv4 addresses and
// UDP ports once a frame proves to be a plain query (QR clear, answer,
// authority and additional counts zero), then one record per name byte past
// the first length byte (bytes below 0x10 shown as '.'), closed by an end
// record or the frame end. A taken byte's record, if any, appears in the
// output register in the next cycle, and a new byte is taken in the same
// cycle that the waiting record is taken. Frames are cut at MAX_FRAME_BYTES.
module dns_query_name_extractor_top import dqne_pkg::*; #(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // frame_byte
	input  logic         s_tlast,   // frame_end
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // source_address, source_port, dest_address,
	                                // dest_port, name_char
	output logic [1:0]   m_tuser,   // record_kind
	output logic         m_tlast    // record_last
);

	logic take;
	logic rec_valid;
	rec_t rec;
	logic out_valid_q;
	rec_t out_q;

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	dqne_parse #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_take  (take),
		.in_byte  (s_tdata),
		.in_end   (s_tlast),
		.rec_valid(rec_valid),
		.rec      (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= rec_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && rec_valid) begin
			out_q <= rec;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.name_char, out_q.dst_port, out_q.dst_addr,
	                   out_q.src_port, out_q.src_addr};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

endmodule
